// ===== design/positional_pid_controller_defines.svh =====
// assertion macros for the positional pid controller checker
// no dependencies; included by the checker file
`ifndef POSITIONAL_PID_CONTROLLER_DEFINES_SVH
`define POSITIONAL_PID_CONTROLLER_DEFINES_SVH

// consequent checked in the same cycle
`define PPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppc checker: property failed");

// consequent checked in the cycle after the antecedent
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppc checker: property failed");

`endif

// ===== design/ppc_pkg.sv =====
// shared widths, types and helpers for the positional pid controller
// no dependencies; used by every rtl file of the block
package ppc_pkg;

	localparam int IntegralWidth = 32;
	localparam int DataWidth     = 16;
	localparam int WindupWidth   = 15;
	localparam int ErrWidth      = 17;
	localparam int DiffWidth     = 18;
	localparam int GainWidth     = 16;
	localparam int DivWidth      = IntegralWidth + 15;
	localparam int SumWidth      = DivWidth + 2;
	localparam int YMagWidth     = 41;
	localparam int ProdWidth     = YMagWidth + GainWidth;
	localparam int DropBits      = 20;
	localparam int RWidth        = ProdWidth - DropBits + 1;
	localparam int DTermMagWidth = 34;
	localparam int DivCntWidth   = $clog2(DivWidth);
	localparam int MulCntWidth   = $clog2(GainWidth);
	localparam int CfgIdxWidth   = 3;

	localparam logic [YMagWidth-1:0] YSatMag = YMagWidth'(1) << 40;
	localparam logic signed [DataWidth-1:0] TermOffRaw = 16'sd25;

	typedef enum logic [CfgIdxWidth-1:0] {
		RegSetpoint       = 3'd0,
		RegGain           = 3'd1,
		RegIntegralTime   = 3'd2,
		RegDerivativeTime = 3'd3,
		RegWindupLimit    = 3'd4,
		RegOutputLow      = 3'd5,
		RegOutputHigh     = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		StIdle,
		StErr,
		StInteg,
		StWindup,
		StStart,
		StWait,
		StAcc1,
		StAcc2,
		StSat,
		StMulGo,
		StMulWait,
		StRound,
		StClamp
	} state_t;

	typedef struct packed {
		logic signed [DataWidth-1:0] setpoint;
		logic signed [DataWidth-1:0] gain;
		logic signed [DataWidth-1:0] integral_time;
		logic signed [DataWidth-1:0] derivative_time;
		logic [WindupWidth-1:0]      windup_limit;
		logic signed [DataWidth-1:0] output_low;
		logic signed [DataWidth-1:0] output_high;
	} cfg_regs_t;

	function automatic logic term_on(input logic signed [DataWidth-1:0] t);
		return (t > TermOffRaw) || (t < -TermOffRaw);
	endfunction

endpackage

// ===== design/ppc_div.sv =====
// bit-serial restoring divider on magnitudes, one quotient bit per cycle
// depends on ppc_pkg
module ppc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ppc_pkg::DivWidth-1:0] dividend,
	input  logic [ppc_pkg::GainWidth-1:0] divisor,
	output logic                         busy,
	output logic [ppc_pkg::DivWidth-1:0] quotient
);

	logic                               busy_q;
	logic [ppc_pkg::DivCntWidth-1:0]    cnt_q;
	logic [ppc_pkg::DivWidth-1:0]       dq_q;
	logic [ppc_pkg::GainWidth-1:0]      rem_q;
	logic [ppc_pkg::GainWidth-1:0]      dvs_q;
	logic [ppc_pkg::GainWidth:0]        rem_next;
	logic [ppc_pkg::GainWidth+1:0]      trial;
	logic                               qbit;

	always_comb begin
		rem_next = {rem_q, dq_q[ppc_pkg::DivWidth-1]};
		trial    = {1'b0, rem_next} - {2'b00, dvs_q};
		qbit     = !trial[ppc_pkg::GainWidth+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ppc_pkg::DivCntWidth'(ppc_pkg::DivWidth - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[ppc_pkg::DivWidth-2:0], qbit};
			rem_q <= qbit ? trial[ppc_pkg::GainWidth-1:0] : rem_next[ppc_pkg::GainWidth-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

// ===== design/ppc_mul.sv =====
// bit-serial shift-add multiplier on magnitudes, one multiplier bit per cycle
// depends on ppc_pkg
module ppc_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ppc_pkg::YMagWidth-1:0]  mcand,
	input  logic [ppc_pkg::GainWidth-1:0]  mplier,
	output logic                           busy,
	output logic [ppc_pkg::ProdWidth-1:0]  product
);

	logic                             busy_q;
	logic [ppc_pkg::MulCntWidth-1:0]  cnt_q;
	logic [ppc_pkg::YMagWidth-1:0]    mc_q;
	logic [ppc_pkg::YMagWidth-1:0]    hi_q;
	logic [ppc_pkg::GainWidth-1:0]    lo_q;
	logic [ppc_pkg::YMagWidth:0]      sum;

	always_comb begin
		sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : (ppc_pkg::YMagWidth + 1)'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ppc_pkg::MulCntWidth'(ppc_pkg::GainWidth - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (busy_q) begin
			hi_q <= sum[ppc_pkg::YMagWidth:1];
			lo_q <= {sum[0], lo_q[ppc_pkg::GainWidth-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = {hi_q, lo_q};

endmodule

// ===== design/positional_pid_controller.sv =====
// positional pid controller: one clamped drive value per process-value sample
// depends on ppc_pkg, ppc_div and ppc_mul
// steps: error, integral, windup, then the bit-serial divider (one quotient bit per cycle)
// beside the derivative multiply, accumulate, saturate, the 16-step serial gain multiplier
// then round and clamp; one item at a time, a waiting result does not block the next input
// reset: asynchronous, active low; registers to defaults, integral and error history cleared
module positional_pid_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [ppc_pkg::DataWidth-1:0]     s_axis_tdata,  // [15:0] process_value
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ppc_pkg::DataWidth-1:0]     m_axis_tdata,  // [15:0] drive
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppc_pkg::CfgIdxWidth-1:0]   cfg_index,
	input  logic [ppc_pkg::DataWidth-1:0]     cfg_data
);

	localparam int IW = ppc_pkg::IntegralWidth;
	localparam int SW = ppc_pkg::SumWidth;
	localparam int RW = ppc_pkg::RWidth;

	ppc_pkg::cfg_regs_t cfg_q;
	ppc_pkg::state_t    state_q, state_d;

	logic signed [IW-1:0]                   integral_q;
	logic signed [ppc_pkg::ErrWidth-1:0]    prev_err_q;
	logic                                   first_q;
	logic                                   out_valid_q;
	logic [ppc_pkg::DataWidth-1:0]          out_q;

	logic signed [ppc_pkg::DataWidth-1:0]   pv_q;
	logic signed [ppc_pkg::ErrWidth-1:0]    err_q;
	logic signed [ppc_pkg::DiffWidth-1:0]   diff_q;
	logic signed [IW-1:0]                   isum_q;
	logic signed [IW-1:0]                   s_q;
	logic                                   isign_q;
	logic                                   dsign_q;
	logic signed [SW-1:0]                   y_q;
	logic [ppc_pkg::YMagWidth-1:0]          ymag_q;
	logic                                   ysign_q;
	logic signed [RW-1:0]                   r_q;

	logic                                   in_xfer;
	logic                                   out_free;
	logic                                   div_start;
	logic                                   mul_start;
	logic                                   div_busy;
	logic                                   mul_busy;
	logic [ppc_pkg::DivWidth-1:0]           div_quot;
	logic [ppc_pkg::ProdWidth-1:0]          mul_prod;
	logic [ppc_pkg::DivWidth-1:0]           div_dividend;
	logic [ppc_pkg::YMagWidth-1:0]          mul_mcand;
	logic [ppc_pkg::GainWidth-1:0]          mul_mplier;

	logic signed [IW+1:0]                   isum_wide;
	logic signed [IW-1:0]                   isum_sat;
	logic signed [IW-1:0]                   wlim;
	logic signed [IW-1:0]                   s_clamp;
	logic [IW-1:0]                          s_mag;
	logic [ppc_pkg::GainWidth-1:0]          it_mag;
	logic [ppc_pkg::GainWidth-1:0]          dt_mag;
	logic [ppc_pkg::GainWidth-1:0]          gain_mag;
	logic [ppc_pkg::DiffWidth-1:0]          diff_mag;
	logic signed [SW-1:0]                   err_term;
	logic signed [SW-1:0]                   q_ext;
	logic signed [SW-1:0]                   q_term;
	logic signed [SW-1:0]                   d_ext;
	logic signed [SW-1:0]                   d_term;
	logic [SW-1:0]                          y_abs;
	logic signed [RW-1:0]                   r_ext;
	logic signed [RW-1:0]                   r_hi;
	logic signed [RW-1:0]                   r_lo;
	logic signed [RW-1:0]                   r_tmp;
	logic signed [RW-1:0]                   r_fin;
	logic                                   use_i;
	logic                                   use_d;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint        <= 16'sd1496;
			cfg_q.gain            <= 16'sd896;
			cfg_q.integral_time   <= 16'sd256;
			cfg_q.derivative_time <= 16'sd0;
			cfg_q.windup_limit    <= 15'd160;
			cfg_q.output_low      <= 16'sd0;
			cfg_q.output_high     <= 16'sd255;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ppc_pkg::reg_idx_t'(cfg_index))
				ppc_pkg::RegSetpoint:       cfg_q.setpoint        <= cfg_data;
				ppc_pkg::RegGain:           cfg_q.gain            <= cfg_data;
				ppc_pkg::RegIntegralTime:   cfg_q.integral_time   <= cfg_data;
				ppc_pkg::RegDerivativeTime: cfg_q.derivative_time <= cfg_data;
				ppc_pkg::RegWindupLimit:
					cfg_q.windup_limit <= cfg_data[ppc_pkg::WindupWidth-1:0];
				ppc_pkg::RegOutputLow:      cfg_q.output_low      <= cfg_data;
				ppc_pkg::RegOutputHigh:     cfg_q.output_high     <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath combinational terms
	always_comb begin
		isum_wide = {{2{integral_q[IW-1]}}, integral_q}
			+ {{(IW + 2 - ppc_pkg::ErrWidth){err_q[ppc_pkg::ErrWidth-1]}}, err_q}
			+ {{(IW + 2 - ppc_pkg::ErrWidth){prev_err_q[ppc_pkg::ErrWidth-1]}}, prev_err_q};
		if (!isum_wide[IW+1] && (isum_wide[IW:IW-1] != 2'b00))
			isum_sat = {1'b0, {(IW - 1){1'b1}}};
		else if (isum_wide[IW+1] && (isum_wide[IW:IW-1] != 2'b11))
			isum_sat = {1'b1, {(IW - 1){1'b0}}};
		else
			isum_sat = isum_wide[IW-1:0];

		wlim = {{(IW - ppc_pkg::WindupWidth - 1){1'b0}}, cfg_q.windup_limit, 1'b0};
		s_clamp = isum_q;
		if (cfg_q.windup_limit != '0) begin
			if (isum_q > wlim)
				s_clamp = wlim;
			else if (isum_q < -wlim)
				s_clamp = -wlim;
		end

		s_mag    = s_q[IW-1] ? -s_q : s_q;
		it_mag   = cfg_q.integral_time[ppc_pkg::DataWidth-1] ?
			-cfg_q.integral_time : cfg_q.integral_time;
		dt_mag   = cfg_q.derivative_time[ppc_pkg::DataWidth-1] ?
			-cfg_q.derivative_time : cfg_q.derivative_time;
		gain_mag = cfg_q.gain[ppc_pkg::DataWidth-1] ? -cfg_q.gain : cfg_q.gain;
		diff_mag = diff_q[ppc_pkg::DiffWidth-1] ? -diff_q : diff_q;

		use_i = !first_q && ppc_pkg::term_on(cfg_q.integral_time);
		use_d = !first_q && ppc_pkg::term_on(cfg_q.derivative_time);

		err_term = {{(SW - ppc_pkg::ErrWidth - 8){err_q[ppc_pkg::ErrWidth-1]}}, err_q, 8'b0};
		q_ext    = {{(SW - ppc_pkg::DivWidth){1'b0}}, div_quot};
		q_term   = isign_q ? -q_ext : q_ext;
		d_ext    = {{(SW - ppc_pkg::DTermMagWidth){1'b0}},
			mul_prod[ppc_pkg::DTermMagWidth-1:0]};
		d_term   = dsign_q ? -d_ext : d_ext;
		y_abs    = y_q[SW-1] ? -y_q : y_q;

		r_ext = {1'b0, mul_prod[ppc_pkg::ProdWidth-1:ppc_pkg::DropBits]};
		r_hi  = {{(RW - ppc_pkg::DataWidth){cfg_q.output_high[ppc_pkg::DataWidth-1]}},
			cfg_q.output_high};
		r_lo  = {{(RW - ppc_pkg::DataWidth){cfg_q.output_low[ppc_pkg::DataWidth-1]}},
			cfg_q.output_low};
		r_tmp = (r_q > r_hi) ? r_hi : r_q;
		r_fin = (r_tmp < r_lo) ? r_lo : r_tmp;

		div_dividend = {s_mag, 15'b0};
		if (state_q == ppc_pkg::StMulGo) begin
			mul_mcand  = ymag_q;
			mul_mplier = gain_mag;
		end else begin
			mul_mcand  = {{(ppc_pkg::YMagWidth - ppc_pkg::DiffWidth){1'b0}}, diff_mag};
			mul_mplier = dt_mag;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ppc_pkg::StIdle;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		mul_start     = 1'b0;
		unique case (state_q)
			ppc_pkg::StIdle: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = ppc_pkg::StErr;
			end
			ppc_pkg::StErr:    state_d = ppc_pkg::StInteg;
			ppc_pkg::StInteg:  state_d = ppc_pkg::StWindup;
			ppc_pkg::StWindup: state_d = ppc_pkg::StStart;
			ppc_pkg::StStart: begin
				div_start = 1'b1;
				mul_start = 1'b1;
				state_d   = ppc_pkg::StWait;
			end
			ppc_pkg::StWait: begin
				if (!div_busy && !mul_busy)
					state_d = ppc_pkg::StAcc1;
			end
			ppc_pkg::StAcc1: state_d = ppc_pkg::StAcc2;
			ppc_pkg::StAcc2: state_d = ppc_pkg::StSat;
			ppc_pkg::StSat:  state_d = ppc_pkg::StMulGo;
			ppc_pkg::StMulGo: begin
				mul_start = 1'b1;
				state_d   = ppc_pkg::StMulWait;
			end
			ppc_pkg::StMulWait: begin
				if (!mul_busy)
					state_d = ppc_pkg::StRound;
			end
			ppc_pkg::StRound: state_d = ppc_pkg::StClamp;
			ppc_pkg::StClamp: begin
				if (out_free)
					state_d = ppc_pkg::StIdle;
			end
			default: state_d = ppc_pkg::StIdle;
		endcase
	end

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q  <= '0;
			prev_err_q  <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ppc_pkg::StWindup) begin
				if (!first_q)
					integral_q <= s_clamp;
				prev_err_q <= err_q;
			end
			if (state_q == ppc_pkg::StClamp && out_free) begin
				out_valid_q <= 1'b1;
				first_q     <= 1'b0;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			pv_q <= s_axis_tdata;
		case (state_q)
			ppc_pkg::StErr:
				err_q <= {cfg_q.setpoint[ppc_pkg::DataWidth-1], cfg_q.setpoint}
					- {pv_q[ppc_pkg::DataWidth-1], pv_q};
			ppc_pkg::StInteg: begin
				isum_q <= isum_sat;
				diff_q <= {err_q[ppc_pkg::ErrWidth-1], err_q}
					- {prev_err_q[ppc_pkg::ErrWidth-1], prev_err_q};
			end
			ppc_pkg::StWindup: s_q <= s_clamp;
			ppc_pkg::StStart: begin
				isign_q <= s_q[IW-1] ^ cfg_q.integral_time[ppc_pkg::DataWidth-1];
				dsign_q <= diff_q[ppc_pkg::DiffWidth-1]
					^ cfg_q.derivative_time[ppc_pkg::DataWidth-1];
			end
			ppc_pkg::StAcc1: y_q <= err_term + (use_i ? q_term : SW'(0));
			ppc_pkg::StAcc2: y_q <= y_q + (use_d ? d_term : SW'(0));
			ppc_pkg::StSat: begin
				ymag_q  <= (y_abs > {{(SW - ppc_pkg::YMagWidth){1'b0}}, ppc_pkg::YSatMag}) ?
					ppc_pkg::YSatMag : y_abs[ppc_pkg::YMagWidth-1:0];
				ysign_q <= y_q[SW-1] ^ cfg_q.gain[ppc_pkg::DataWidth-1];
			end
			ppc_pkg::StRound: r_q <= ysign_q ? -r_ext : r_ext;
			ppc_pkg::StClamp: begin
				if (out_free)
					out_q <= r_fin[ppc_pkg::DataWidth-1:0];
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	ppc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (it_mag),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	ppc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.busy    (mul_busy),
		.product (mul_prod)
	);

endmodule

// ===== design/ppc_checker.sv =====
// port-level checks for the positional pid controller, bound to the top level
// depends on positional_pid_controller_defines.svh and ppc_pkg
`include "positional_pid_controller_defines.svh"

module ppc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [ppc_pkg::DataWidth-1:0] m_axis_tdata
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// a stalled result holds
	`PPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// one item at a time: busy after each input transfer
	`PPC_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_xfer, !s_axis_tready)
	// a new result appears only as the block returns to idle
	`PPC_ASSERT_SAME(a_result_idle, clk, arst_n, $rose(m_axis_tvalid), s_axis_tready)
	// no result can follow an input transfer directly
	`PPC_ASSERT_NEXT(a_no_fast_result, clk, arst_n, in_xfer, !$rose(m_axis_tvalid))

endmodule

bind positional_pid_controller ppc_checker u_checker (.*);
